// ===== sv/pdrf_pkg.sv =====
package pdrf_pkg;

	localparam int SLOTS_DEFAULT = 100;
	localparam int RAMP_W_DEFAULT = 16;

	localparam int DUTY_W = 7;
	localparam int RAMP_REG_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_START_DUTY = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_DUTY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_PERIODS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CYCLE_ENABLE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_ENABLE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RUN_ENABLE = 3'd5;

	localparam logic [DUTY_W-1:0] START_DUTY_RST = 7'd100;
	localparam logic [DUTY_W-1:0] TARGET_DUTY_RST = 7'd75;
	localparam logic [RAMP_REG_W-1:0] RAMP_PERIODS_RST = 16'd250;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} state_t;

	typedef struct packed {
		logic take;
		logic div_step;
		logic div_last;
	} cmd_t;

	typedef struct packed {
		logic ramp_start;
	} sts_t;

endpackage

// ===== sv/pdrf_ctrl.sv =====
module pdrf_ctrl #(
	parameter int RAMP_COUNT_WIDTH = pdrf_pkg::RAMP_W_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	input  pdrf_pkg::sts_t   sts,
	output pdrf_pkg::cmd_t   cmd
);
	import pdrf_pkg::*;

	localparam int CNT_W = $clog2(RAMP_COUNT_WIDTH);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RAMP_COUNT_WIDTH - 1);

	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic valid_q;
	logic take;

	assign s_tready = (state_q == ST_IDLE) && (!valid_q || m_tready);
	assign take = s_tvalid && s_tready;
	assign m_tvalid = valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (take && sts.ramp_start)
					state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CNT_LAST)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.take = take;
		cmd.div_step = 1'b0;
		cmd.div_last = 1'b0;
		unique case (state_q)
			ST_IDLE: ;
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cmd.div_last = (cnt_q == CNT_LAST);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DIV)
				cnt_q <= cnt_q + 1'b1;
			else
				cnt_q <= '0;
			if (take)
				valid_q <= 1'b1;
			else if (m_tready)
				valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/pdrf_dp.sv =====
module pdrf_dp #(
	parameter int SLOTS_PER_PERIOD = pdrf_pkg::SLOTS_DEFAULT,
	parameter int RAMP_COUNT_WIDTH = pdrf_pkg::RAMP_W_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              advance,
	input  logic                              cfg_we,
	input  logic [pdrf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pdrf_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  pdrf_pkg::cmd_t                    cmd,
	output pdrf_pkg::sts_t                    sts,
	output logic                              pin_level,
	output logic [pdrf_pkg::DUTY_W-1:0]       duty_now,
	output logic                              ramping
);
	import pdrf_pkg::*;

	localparam int W = RAMP_COUNT_WIDTH;
	localparam int SLOT_W = $clog2(SLOTS_PER_PERIOD);
	localparam int CMP_W = (SLOT_W > DUTY_W) ? SLOT_W : DUTY_W;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS_PER_PERIOD - 1);

	logic [RAMP_REG_W-1:0] ramp_q;
	logic cycle_q, smooth_q, run_q;

	logic [SLOT_W-1:0] slot_q;
	logic [DUTY_W-1:0] duty_q, goal_q, origin_q;
	logic [W-1:0] pc_q, si_q, ic_q;
	logic down_q, active_q;

	logic [DUTY_W-1:0] rem_q, dvs_q;
	logic [W-1:0] quo_q;

	logic pin_q, ramping_q;
	logic [DUTY_W-1:0] duty_now_q;

	logic go;
	logic [W-1:0] len;
	logic hit, start, jump;
	logic [DUTY_W-1:0] duty_b, goal_b, steps;
	logic down_b;

	logic at_end;
	logic [W-1:0] pc_dec, ic_inc;
	logic stepping;
	logic [DUTY_W-1:0] duty_e;

	logic [DUTY_W:0] shifted;
	logic ge;
	logic [DUTY_W-1:0] rem_n;
	logic [W-1:0] quo_n;

	assign go = advance && run_q;
	assign len = W'(ramp_q);

	always_comb begin
		hit = 1'b0;
		goal_b = goal_q;
		if (go && slot_q == '0 && !active_q) begin
			if (duty_q == goal_q) begin
				if (cycle_q) begin
					goal_b = origin_q;
					hit = (duty_q != origin_q);
				end
			end else begin
				hit = 1'b1;
			end
		end
		jump = hit && (len == '0);
		start = hit && (len != '0);
		duty_b = jump ? goal_b : duty_q;
		down_b = goal_b < duty_q;
		steps = down_b ? (duty_q - goal_b) : (goal_b - duty_q);
	end

	assign sts.ramp_start = start;

	always_comb begin
		at_end = go && (slot_q == SLOT_LAST) && active_q;
		pc_dec = pc_q - 1'b1;
		ic_inc = ic_q + 1'b1;
		stepping = ic_inc >= si_q;
		duty_e = duty_q;
		if (stepping && smooth_q) begin
			if (down_q && duty_q > goal_q)
				duty_e = duty_q - 1'b1;
			else if (!down_q && duty_q < goal_q)
				duty_e = duty_q + 1'b1;
		end
		if (pc_dec == '0)
			duty_e = goal_q;
	end

	always_comb begin
		shifted = {rem_q, quo_q[W-1]};
		ge = shifted >= {1'b0, dvs_q};
		rem_n = ge ? DUTY_W'(shifted - {1'b0, dvs_q}) : shifted[DUTY_W-1:0];
		quo_n = {quo_q[W-2:0], ge};
	end

	always_ff @(posedge clk) begin
		if (cmd.take && start) begin
			rem_q <= '0;
			quo_q <= len;
			dvs_q <= steps;
		end else if (cmd.div_step) begin
			rem_q <= rem_n;
			quo_q <= quo_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			pin_q <= run_q && (CMP_W'(slot_q) < CMP_W'(duty_b));
			duty_now_q <= duty_b;
			ramping_q <= active_q || start;
		end
	end

	assign pin_level = pin_q;
	assign duty_now = duty_now_q;
	assign ramping = ramping_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_q <= RAMP_PERIODS_RST;
			cycle_q <= 1'b1;
			smooth_q <= 1'b1;
			run_q <= 1'b1;
			slot_q <= '0;
			duty_q <= START_DUTY_RST;
			goal_q <= TARGET_DUTY_RST;
			origin_q <= START_DUTY_RST;
			pc_q <= '0;
			si_q <= '0;
			ic_q <= '0;
			down_q <= 1'b0;
			active_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_DUTY: begin
					duty_q <= cfg_wdata[DUTY_W-1:0];
					origin_q <= cfg_wdata[DUTY_W-1:0];
				end
				REG_TARGET_DUTY: begin
					goal_q <= cfg_wdata[DUTY_W-1:0];
				end
				REG_RAMP_PERIODS: ramp_q <= cfg_wdata[RAMP_REG_W-1:0];
				REG_CYCLE_ENABLE: cycle_q <= cfg_wdata[0];
				REG_SMOOTH_ENABLE: smooth_q <= cfg_wdata[0];
				REG_RUN_ENABLE: run_q <= cfg_wdata[0];
				default: ;
			endcase
		end else begin
			if (cmd.div_last)
				si_q <= (quo_n == '0) ? W'(1) : quo_n;
			if (cmd.take && go) begin
				if (slot_q == SLOT_LAST)
					slot_q <= '0;
				else
					slot_q <= slot_q + 1'b1;
				goal_q <= goal_b;
				if (at_end) begin
					pc_q <= pc_dec;
					ic_q <= stepping ? '0 : ic_inc;
					duty_q <= duty_e;
					if (pc_dec == '0)
						active_q <= 1'b0;
				end else begin
					duty_q <= duty_b;
					if (start) begin
						origin_q <= duty_q;
						down_q <= down_b;
						pc_q <= len;
						ic_q <= '0;
						active_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

// ===== sv/pwm_duty_ramp_fader.sv =====
// PWM duty ramp fader: drives one PWM pin with SLOTS_PER_PERIOD slots per period
// and fades the duty one step of 1/SLOTS_PER_PERIOD at a time between two levels if smooth_enable is set.
// Input stream s_*: one word per slot; tdata[0] = advance (1 moves a slot on, if run_enable).
// Output stream m_*: one word per input word: pin level, duty in use, ramp flag.
// Config port: cfg_we writes cfg_wdata into register cfg_index (0 start_duty,
// 1 target_duty, 2 ramp_periods, 3 cycle_enable, 4 smooth_enable, 5 run_enable).
// The result of a word is registered and shows on m_tvalid in the cycle after it is taken.
// Throughput: one word per cycle while the receiver is ready, except after a word
// that starts a ramp: the step interval is then found by a restoring divider, one
// quotient bit per cycle, and s_tready stays low while the divider runs.
// A stalled receiver holds the result register; a new word is taken in the cycle
// the waiting result leaves.
// Reset loads the register defaults (100, 75, 250, 1, 1, 1), puts the duty at
// start_duty and the slot count at zero, with no ramp in progress.
module pwm_duty_ramp_fader #(
	parameter int SLOTS_PER_PERIOD = pdrf_pkg::SLOTS_DEFAULT,
	parameter int RAMP_COUNT_WIDTH = pdrf_pkg::RAMP_W_DEFAULT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [pdrf_pkg::IN_DATA_W-1:0]    s_tdata,   // [0] advance
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [pdrf_pkg::OUT_DATA_W-1:0]   m_tdata,   // [0] pin_level, [7:1] duty_now, [8] ramping
	input  logic                              cfg_we,
	input  logic [pdrf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [pdrf_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
	import pdrf_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic pin_level, ramping;
	logic [DUTY_W-1:0] duty_now;
	logic unused_in;

	assign unused_in = ^s_tdata[IN_DATA_W-1:1];

	pdrf_ctrl #(
		.RAMP_COUNT_WIDTH(RAMP_COUNT_WIDTH)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.sts(sts),
		.cmd(cmd)
	);

	pdrf_dp #(
		.SLOTS_PER_PERIOD(SLOTS_PER_PERIOD),
		.RAMP_COUNT_WIDTH(RAMP_COUNT_WIDTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.advance(s_tdata[0] ^ (unused_in & 1'b0)),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cmd(cmd),
		.sts(sts),
		.pin_level(pin_level),
		.duty_now(duty_now),
		.ramping(ramping)
	);

	assign m_tdata = {{(OUT_DATA_W - DUTY_W - 2){1'b0}}, ramping, duty_now, pin_level};

	a_ramp_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.take && sts.ramp_start) |=> !s_tready)
		else $error("input taken while step interval divide runs");

	a_take_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> m_tvalid)
		else $error("taken word gave no result");

	a_pin_duty: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[0]) |-> (m_tdata[7:1] != '0))
		else $error("pin high at zero duty");

endmodule
